>>> hw/rtl/lsd2x_pkg.sv
// Shared constants, lookup tables and stage types of the 2x sprite row drawer.
package lsd2x_pkg;

  // Screen geometry in high-resolution pixels
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;

  // Sprite row and read word sizes
  localparam int SPRITE_BITS = 8;
  localparam int WIDE_ROW    = 16;
  localparam int WORD_W      = 64;

  // Derived widths
  localparam int XW      = $clog2(SCREEN_WIDTH);        // x0 < SCREEN_WIDTH
  localparam int YW      = $clog2(SCREEN_HEIGHT);       // y0 < SCREEN_HEIGHT
  localparam int LINE_W  = $clog2(SCREEN_HEIGHT + 31);  // y0 + 2*row, up to H+28
  localparam int DEPTH   = (SCREEN_HEIGHT + 1) / 2;     // lines per bank (even/odd)
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int PAD_W   = (SCREEN_WIDTH > 2 * WORD_W) ? SCREEN_WIDTH : 2 * WORD_W;
  localparam int IN_DW   = 40;
  localparam int OUT_DW  = 72;

  // Mode codes carried in the input tuser bit
  typedef enum logic {
    MODE_DRAW = 1'b0,
    MODE_READ = 1'b1
  } mode_e;

  // Doubled-and-wrapped origin tables, one entry per low-resolution coordinate
  typedef logic [255:0][XW-1:0] x0_lut_t;
  typedef logic [255:0][YW-1:0] y0_lut_t;

  function automatic x0_lut_t build_x0_lut();
    x0_lut_t lut;
    for (int i = 0; i < 256; i++) begin
      lut[i] = XW'((2 * i) % SCREEN_WIDTH);
    end
    return lut;
  endfunction

  function automatic y0_lut_t build_y0_lut();
    y0_lut_t lut;
    for (int i = 0; i < 256; i++) begin
      lut[i] = YW'((2 * i) % SCREEN_HEIGHT);
    end
    return lut;
  endfunction

  localparam x0_lut_t X0_LUT = build_x0_lut();
  localparam y0_lut_t Y0_LUT = build_y0_lut();

  // Item as held in the work stage
  typedef struct packed {
    mode_e                  mode;
    logic [XW-1:0]          x0;
    logic [SPRITE_BITS-1:0] row_bits;
    logic                   last_row;
    logic                   draw_ok;    // target line lies on screen
    logic                   below_ok;   // line below exists
    logic [IDX_W-1:0]       idx;        // bank entry of the line pair
    logic                   read_bank;  // 1 selects the odd line
    logic                   read_half;
    logic                   read_ok;    // read line lies on screen
  } item_t;

  // Outcome of the work stage
  typedef struct packed {
    logic                    wr_even;
    logic                    wr_odd;
    logic [SCREEN_WIDTH-1:0] even_line;
    logic [SCREEN_WIDTH-1:0] odd_line;
    logic                    collision;
    logic                    row_drawn;
    logic [WORD_W-1:0]       pixel_word;
    logic                    hit_flag;
  } result_t;

endpackage

>>> hw/rtl/lsd2x_ram.sv
// Generic one-write one-read RAM with registered read data.
module lsd2x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, old data on a same-cycle write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hw/rtl/lsd2x_row_unit.sv
// Combinational row work: 2x sprite XOR with line copy, collision, word read.
module lsd2x_row_unit (
  input  lsd2x_pkg::item_t                      item_i,
  input  logic [lsd2x_pkg::SCREEN_WIDTH-1:0]    even_line_i,
  input  logic [lsd2x_pkg::SCREEN_WIDTH-1:0]    odd_line_i,
  input  logic                                  hit_flag_i,
  output lsd2x_pkg::result_t                    result_o
);
  import lsd2x_pkg::*;

  logic [SCREEN_WIDTH-1:0] prev_e;
  logic [SCREEN_WIDTH-1:0] new_e;
  logic [SCREEN_WIDTH-1:0] new_o;
  logic                    hits;
  logic [XW:0]             diff;
  logic                    vis;
  logic                    lit;
  logic [3:0]              off;
  logic [PAD_W-1:0]        rd_pad;
  logic [WORD_W-1:0]       word;
  logic                    hit_now;
  logic                    is_draw;

  // Left neighbor of every column
  assign prev_e = {even_line_i[SCREEN_WIDTH-2:0], 1'b0};

  // Per-column update over the 16-pixel window starting at x0
  always_comb begin
    new_e = even_line_i;
    new_o = odd_line_i;
    hits  = 1'b0;
    diff  = '0;
    vis   = 1'b0;
    lit   = 1'b0;
    off   = '0;
    for (int c = 0; c < SCREEN_WIDTH; c++) begin
      diff = {1'b0, XW'(c)} - {1'b0, item_i.x0};
      vis  = !diff[XW] && (diff < (XW + 1)'(WIDE_ROW));
      off  = diff[3:0];
      // sprite bit 7 covers offsets 0 and 1
      lit  = item_i.row_bits[~off[3:1]];
      if (vis && lit) begin
        hits = hits | even_line_i[c];
        // odd offset takes the freshly toggled left neighbor
        new_e[c] = off[0] ? ~prev_e[c] : ~even_line_i[c];
      end
      if (vis) begin
        new_o[c] = new_e[c];
      end
    end
  end

  // Word read from the selected line
  always_comb begin
    rd_pad = PAD_W'(item_i.read_bank ? odd_line_i : even_line_i);
    word   = '0;
    for (int i = 0; i < WORD_W; i++) begin
      word[WORD_W-1-i] = rd_pad[{item_i.read_half, 6'(i)}];
    end
  end

  assign is_draw = (item_i.mode == MODE_DRAW);
  assign hit_now = hit_flag_i | (item_i.draw_ok & hits);

  // Outcome
  always_comb begin
    result_o.even_line = new_e;
    result_o.odd_line  = new_o;
    if (is_draw) begin
      result_o.wr_even    = item_i.draw_ok;
      result_o.wr_odd     = item_i.draw_ok & item_i.below_ok;
      result_o.collision  = hit_now;
      result_o.row_drawn  = item_i.draw_ok;
      result_o.pixel_word = '0;
      result_o.hit_flag   = item_i.last_row ? 1'b0 : hit_now;
    end else begin
      result_o.wr_even    = 1'b0;
      result_o.wr_odd     = 1'b0;
      result_o.collision  = hit_flag_i;
      result_o.row_drawn  = 1'b0;
      result_o.pixel_word = item_i.read_ok ? word : '0;
      result_o.hit_flag   = hit_flag_i;
    end
  end

endmodule

>>> hw/rtl/lowres_sprite_draw_2x_core.sv
// Top level of the 2x low-resolution sprite row drawer with its framebuffer.
//
// Input stream (s_axis): one item per transfer. tuser is the mode (0 draws one
// sprite row, 1 reads a 64-pixel framebuffer word), tlast marks the last row
// of a sprite. Output stream (m_axis): exactly one result per item, in order.
// An accepted item passes through the work stage and result registers to
// m_axis. Throughput: one item per cycle while m_axis_tready is high, since a
// row draw reads its line pair in the accept cycle and writes it back as it
// leaves; a one-entry bypass per bank covers a read of a pair being written.
// The framebuffer is two RAM banks of even and odd lines, each entry a whole
// line, so every draw touches one entry per bank.
// Reset: the collision flag clears and every line reads as blank at once
// through per-entry valid bits; there is no clearing pass.
// Stall: when m_axis_tready is low the result register holds, the work stage
// fills, and then s_axis_tready drops until the result is taken.
module lowres_sprite_draw_2x_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // s_axis_tdata, low bit up: sprite_x[7:0], sprite_y[7:0], row_number[3:0],
  // row_bits[7:0], read_line[5:0], read_half, zero fill[4:0]
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [lsd2x_pkg::IN_DW-1:0]    s_axis_tdata,
  input  logic                           s_axis_tlast,   // last_row
  input  logic                           s_axis_tuser,   // mode
  // m_axis_tdata, low bit up: collision, row_drawn, pixel_word[63:0], zero fill[5:0]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [lsd2x_pkg::OUT_DW-1:0]   m_axis_tdata
);
  import lsd2x_pkg::*;

  logic                    in_xfer;
  logic [7:0]              in_sx;
  logic [7:0]              in_sy;
  logic [3:0]              in_row;
  logic [5:0]              in_rline;
  logic [LINE_W-1:0]       in_line;
  item_t                   in_item;

  logic                    s1_valid_q;
  item_t                   s1_item_q;
  logic                    s1_vld_e_q;
  logic                    s1_vld_o_q;
  logic                    s1_adv;

  logic [DEPTH-1:0]        vld_e_q;
  logic [DEPTH-1:0]        vld_o_q;

  logic                    fwd_e_vld_q;
  logic [IDX_W-1:0]        fwd_e_idx_q;
  logic [SCREEN_WIDTH-1:0] fwd_e_data_q;
  logic                    fwd_o_vld_q;
  logic [IDX_W-1:0]        fwd_o_idx_q;
  logic [SCREEN_WIDTH-1:0] fwd_o_data_q;

  logic [SCREEN_WIDTH-1:0] ram_e_rdata;
  logic [SCREEN_WIDTH-1:0] ram_o_rdata;
  logic [SCREEN_WIDTH-1:0] line_e;
  logic [SCREEN_WIDTH-1:0] line_o;

  logic                    flag_q;
  result_t                 res;

  logic                    out_valid_q;
  logic [OUT_DW-1:0]       out_data_q;

  // Handshake
  assign s1_adv        = s1_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~s1_valid_q | s1_adv;
  assign in_xfer       = s_axis_tvalid & s_axis_tready;

  // Field unpack
  assign in_sx    = s_axis_tdata[7:0];
  assign in_sy    = s_axis_tdata[15:8];
  assign in_row   = s_axis_tdata[19:16];
  assign in_rline = s_axis_tdata[33:28];

  // Target line and bank entry
  assign in_line = LINE_W'(Y0_LUT[in_sy]) + LINE_W'({in_row, 1'b0});

  always_comb begin
    in_item.mode      = mode_e'(s_axis_tuser);
    in_item.x0        = X0_LUT[in_sx];
    in_item.row_bits  = s_axis_tdata[27:20];
    in_item.last_row  = s_axis_tlast;
    in_item.draw_ok   = in_line < LINE_W'(SCREEN_HEIGHT);
    in_item.below_ok  = in_line < LINE_W'(SCREEN_HEIGHT - 1);
    in_item.read_bank = in_rline[0];
    in_item.read_half = s_axis_tdata[34];
    in_item.read_ok   = 8'(in_rline) < 8'(SCREEN_HEIGHT);
    if (mode_e'(s_axis_tuser) == MODE_READ) begin
      in_item.idx = IDX_W'(in_rline[5:1]);
    end else begin
      in_item.idx = IDX_W'(in_line[LINE_W-1:1]);
    end
  end

  // Framebuffer banks
  lsd2x_ram #(
    .WIDTH (SCREEN_WIDTH),
    .DEPTH (DEPTH)
  ) u_even_ram (
    .clk_i     (clk_i),
    .wr_en_i   (s1_adv & res.wr_even),
    .wr_addr_i (s1_item_q.idx),
    .wr_data_i (res.even_line),
    .rd_en_i   (in_xfer),
    .rd_addr_i (in_item.idx),
    .rd_data_o (ram_e_rdata)
  );

  lsd2x_ram #(
    .WIDTH (SCREEN_WIDTH),
    .DEPTH (DEPTH)
  ) u_odd_ram (
    .clk_i     (clk_i),
    .wr_en_i   (s1_adv & res.wr_odd),
    .wr_addr_i (s1_item_q.idx),
    .wr_data_i (res.odd_line),
    .rd_en_i   (in_xfer),
    .rd_addr_i (in_item.idx),
    .rd_data_o (ram_o_rdata)
  );

  // Work stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  // Work stage payload and entry valid snapshot
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q  <= in_item;
      s1_vld_e_q <= vld_e_q[in_item.idx];
      s1_vld_o_q <= vld_o_q[in_item.idx];
    end
  end

  // Line valid bits: an entry never written reads as blank
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_e_q <= '0;
      vld_o_q <= '0;
    end else if (s1_adv) begin
      if (res.wr_even) begin
        vld_e_q[s1_item_q.idx] <= 1'b1;
      end
      if (res.wr_odd) begin
        vld_o_q[s1_item_q.idx] <= 1'b1;
      end
    end
  end

  // Bypass of the latest write in each bank
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_e_vld_q <= 1'b0;
      fwd_o_vld_q <= 1'b0;
    end else if (s1_adv) begin
      if (res.wr_even) begin
        fwd_e_vld_q <= 1'b1;
      end
      if (res.wr_odd) begin
        fwd_o_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && res.wr_even) begin
      fwd_e_idx_q  <= s1_item_q.idx;
      fwd_e_data_q <= res.even_line;
    end
    if (s1_adv && res.wr_odd) begin
      fwd_o_idx_q  <= s1_item_q.idx;
      fwd_o_data_q <= res.odd_line;
    end
  end

  // Current line pair seen by the work stage
  always_comb begin
    if (fwd_e_vld_q && (fwd_e_idx_q == s1_item_q.idx)) begin
      line_e = fwd_e_data_q;
    end else begin
      line_e = s1_vld_e_q ? ram_e_rdata : '0;
    end
    if (fwd_o_vld_q && (fwd_o_idx_q == s1_item_q.idx)) begin
      line_o = fwd_o_data_q;
    end else begin
      line_o = s1_vld_o_q ? ram_o_rdata : '0;
    end
  end

  lsd2x_row_unit u_row_unit (
    .item_i      (s1_item_q),
    .even_line_i (line_e),
    .odd_line_i  (line_o),
    .hit_flag_i  (flag_q),
    .result_o    (res)
  );

  // Sticky collision flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else if (s1_adv) begin
      flag_q <= res.hit_flag;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= {6'b0, res.pixel_word, res.row_drawn, res.collision};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
